>>> design/lpfp_pkg.sv
// Shared types for the length-prefixed frame parser.
package lpfp_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned FieldW = 16;

  // One-hot parse phases.
  typedef enum logic [3:0] {
    PH_ID      = 4'b0001,
    PH_TYPE    = 4'b0010,
    PH_LEN     = 4'b0100,
    PH_PAYLOAD = 4'b1000
  } lpfp_phase_t;

  // Result of one received byte.
  typedef struct packed {
    logic              header_done;
    logic [FieldW-1:0] message_id;
    logic [FieldW-1:0] message_type;
    logic [FieldW-1:0] payload_length;
    logic              payload_valid;
    logic [ByteW-1:0]  payload_byte;
    logic              frame_last;
  } lpfp_result_t;

endpackage

>>> design/lpfp_core.sv
// Parse state registers and per-byte next-state and result logic.
module lpfp_core
  import lpfp_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                advance,
  input  logic [ByteW-1:0]    rx_byte,
  output lpfp_result_t        result
);

  lpfp_phase_t       phase, phase_next;
  logic              low, low_next;
  logic [FieldW-1:0] id_reg, id_next;
  logic [FieldW-1:0] type_reg, type_next;
  logic [FieldW-1:0] len_reg, len_next;
  logic [FieldW-1:0] remaining, remaining_next;
  logic              hdr_done, pl_valid, last;

  always_comb begin
    phase_next     = phase;
    low_next       = low;
    id_next        = id_reg;
    type_next      = type_reg;
    len_next       = len_reg;
    remaining_next = remaining;
    hdr_done       = 1'b0;
    pl_valid       = 1'b0;
    last           = 1'b0;
    case (phase)
      PH_ID: begin
        id_next  = low ? {id_reg[FieldW-1:ByteW], rx_byte} : {rx_byte, {ByteW{1'b0}}};
        low_next = ~low;
        if (low) begin
          phase_next = PH_TYPE;
        end
      end
      PH_TYPE: begin
        type_next = low ? {type_reg[FieldW-1:ByteW], rx_byte} : {rx_byte, {ByteW{1'b0}}};
        low_next  = ~low;
        if (low) begin
          phase_next = PH_LEN;
        end
      end
      PH_LEN: begin
        len_next = low ? {len_reg[FieldW-1:ByteW], rx_byte} : {rx_byte, {ByteW{1'b0}}};
        low_next = ~low;
        if (low) begin
          hdr_done       = 1'b1;
          remaining_next = len_next;
          // empty payload: the length byte closes the frame
          if (len_next == '0) begin
            last       = 1'b1;
            phase_next = PH_ID;
          end else begin
            phase_next = PH_PAYLOAD;
          end
        end
      end
      PH_PAYLOAD: begin
        pl_valid = 1'b1;
        if (remaining <= FieldW'(1)) begin
          remaining_next = '0;
          last           = 1'b1;
          phase_next     = PH_ID;
          low_next       = 1'b0;
        end else begin
          remaining_next = remaining - FieldW'(1);
        end
      end
      default: begin
        phase_next = PH_ID;
        low_next   = 1'b0;
      end
    endcase
  end

  always_comb begin
    result.header_done    = hdr_done;
    result.message_id     = id_next;
    result.message_type   = type_next;
    result.payload_length = len_next;
    result.payload_valid  = pl_valid;
    result.payload_byte   = pl_valid ? rx_byte : '0;
    result.frame_last     = last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_ID;
      low       <= 1'b0;
      id_reg    <= '0;
      type_reg  <= '0;
      len_reg   <= '0;
      remaining <= '0;
    end else if (advance) begin
      phase     <= phase_next;
      low       <= low_next;
      id_reg    <= id_next;
      type_reg  <= type_next;
      len_reg   <= len_next;
      remaining <= remaining_next;
    end
  end

endmodule

>>> design/length_prefixed_frame_parser.sv
// Length-prefixed frame parser: one result per byte. Each accepted byte yields one result,
// registered in the output register. A new byte is taken in every cycle that the output
// register is empty or being drained, so while m_axis_tready stays high the sustained rate
// is one byte per clock; the single output register and the downstream m_axis_tready set
// it. Frames are a big-endian 16-bit id, type and length followed by length payload bytes;
// a zero length ends the frame on its last length byte, and the byte after a frame's last
// byte begins the next header.
module length_prefixed_frame_parser
  import lpfp_pkg::*;
(
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [7:0]                    s_axis_tdata,  // [7:0] rx_byte
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // [15:0] message_id, [31:16] message_type, [47:32] payload_length, [55:48] payload_byte
  output logic [3*FieldW+ByteW-1:0]     m_axis_tdata,
  output logic [1:0]                    m_axis_tuser,  // [0] header_done, [1] payload_valid
  output logic                          m_axis_tlast   // frame_last
);

  logic         accept;
  lpfp_result_t result;
  lpfp_result_t out_reg;
  logic         out_valid;

  assign s_axis_tready = ~out_valid | m_axis_tready;
  assign accept        = s_axis_tvalid & s_axis_tready;

  lpfp_core u_core (
    .clk     (clk),
    .rst     (rst),
    .advance (accept),
    .rx_byte (s_axis_tdata),
    .result  (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  // hold the result until taken
  always_ff @(posedge clk) begin
    if (accept) begin
      out_reg <= result;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {out_reg.payload_byte, out_reg.payload_length,
                          out_reg.message_type, out_reg.message_id};
  assign m_axis_tuser  = {out_reg.payload_valid, out_reg.header_done};
  assign m_axis_tlast  = out_reg.frame_last;

  a_header_not_payload: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !(m_axis_tuser[0] && m_axis_tuser[1]))
    else $error("header_done and payload_valid both set");

  a_last_kind: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tlast) |-> (m_axis_tuser[0] || m_axis_tuser[1]))
    else $error("frame end on a header byte that did not finish the header");

  a_empty_frame_ends: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser[0] && out_reg.payload_length == '0) |-> m_axis_tlast)
    else $error("empty frame not closed on its header");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty output register");

endmodule

>>> bench/tb_top.sv
// Self-checking bench for the length-prefixed frame parser: byte stream in, one result per byte.
module tb_top
  import lpfp_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned RunLimit  = 1000000;
  localparam int unsigned ShowLimit = 10;
  localparam int unsigned BulkBytes = 800;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      s_axis_tvalid = 1'b0;
  logic                      s_axis_tready;
  logic [7:0]                s_axis_tdata = '0;
  logic                      m_axis_tvalid;
  logic                      m_axis_tready = 1'b0;
  logic [3*FieldW+ByteW-1:0] m_axis_tdata;
  logic [1:0]                m_axis_tuser;
  logic                      m_axis_tlast;

  length_prefixed_frame_parser dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  // Stream bytes waiting to be sent, and predicted results of accepted bytes.
  logic [7:0]   rx_stream[$];
  lpfp_result_t parse_expect[$];

  // Predictor copy of the parser state.
  lpfp_phase_t       pr_phase;
  logic              pr_low;
  logic [FieldW-1:0] pr_id;
  logic [FieldW-1:0] pr_type;
  logic [FieldW-1:0] pr_len;
  logic [FieldW-1:0] pr_left;

  int unsigned bytes_accepted = 0;
  int unsigned phase_a_end    = 0;
  int unsigned phase_b_end    = 0;
  int unsigned cycles         = 0;
  int unsigned errors         = 0;
  int unsigned mismatches     = 0;
  int unsigned results_seen   = 0;
  int unsigned headers_seen   = 0;
  int unsigned payload_seen   = 0;
  int unsigned frames_seen    = 0;
  int unsigned frames_queued  = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic logic [FieldW-1:0] put_field_byte(logic [FieldW-1:0] cur, logic [7:0] b,
                                                       logic low);
    // High byte clears the low half; low byte keeps the high half.
    if (low) begin
      return {cur[FieldW-1:8], b};
    end
    return {b, 8'h00};
  endfunction

  function automatic lpfp_result_t parse_byte(logic [7:0] b);
    lpfp_result_t r;
    r = '0;
    case (pr_phase)
      PH_ID: begin
        pr_id = put_field_byte(pr_id, b, pr_low);
        if (pr_low) pr_phase = PH_TYPE;
        pr_low = ~pr_low;
      end
      PH_TYPE: begin
        pr_type = put_field_byte(pr_type, b, pr_low);
        if (pr_low) pr_phase = PH_LEN;
        pr_low = ~pr_low;
      end
      PH_LEN: begin
        pr_len = put_field_byte(pr_len, b, pr_low);
        if (pr_low) begin
          r.header_done = 1'b1;
          pr_left = pr_len;
          if (pr_len == '0) begin
            r.frame_last = 1'b1;
            pr_phase = PH_ID;
          end else begin
            pr_phase = PH_PAYLOAD;
          end
        end
        pr_low = ~pr_low;
      end
      default: begin
        r.payload_valid = 1'b1;
        r.payload_byte  = b;
        if (pr_left <= 1) begin
          pr_left = '0;
          r.frame_last = 1'b1;
          pr_phase = PH_ID;
          pr_low = 1'b0;
        end else begin
          pr_left = pr_left - 1'b1;
        end
      end
    endcase
    r.message_id     = pr_id;
    r.message_type   = pr_type;
    r.payload_length = pr_len;
    return r;
  endfunction

  task automatic queue_frame(logic [15:0] id, logic [15:0] kind, logic [15:0] len,
                             bit fill_random);
    rx_stream.push_back(id[15:8]);
    rx_stream.push_back(id[7:0]);
    rx_stream.push_back(kind[15:8]);
    rx_stream.push_back(kind[7:0]);
    rx_stream.push_back(len[15:8]);
    rx_stream.push_back(len[7:0]);
    for (int unsigned i = 0; i < len; i++) begin
      rx_stream.push_back(fill_random ? 8'($urandom) : 8'(i));
    end
    frames_queued++;
  endtask

  function automatic logic [15:0] pick_field();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 8) return 16'h0000;
    if (roll < 16) return 16'hFFFF;
    return 16'($urandom);
  endfunction

  function automatic logic [15:0] pick_length();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 10) return 16'd0;
    if (roll < 80) return 16'($urandom_range(1, 12));
    if (roll < 96) return 16'($urandom_range(13, 64));
    return 16'($urandom_range(256, 300));
  endfunction

  function automatic bit sender_holds();
    if (bytes_accepted < phase_a_end) return $urandom_range(0, 99) < 26;
    if (bytes_accepted < phase_b_end) return $urandom_range(0, 99) < 62;
    return 1'b0;
  endfunction

  function automatic bit receiver_holds();
    if (bytes_accepted < phase_a_end) return $urandom_range(0, 99) < 62;
    if (bytes_accepted < phase_b_end) return $urandom_range(0, 99) < 26;
    return 1'b0;
  endfunction

  // Driver: predict on acceptance, then present the next byte or idle.
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        parse_expect.push_back(parse_byte(s_axis_tdata));
        bytes_accepted <= bytes_accepted + 1;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (rx_stream.size() != 0 && !sender_holds()) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= rx_stream.pop_front();
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    m_axis_tready <= rst ? 1'b0 : !receiver_holds();
  end

  // Monitor: compare each accepted result with the oldest prediction.
  always @(posedge clk) begin
    lpfp_result_t want;
    lpfp_result_t got;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got.header_done    = m_axis_tuser[0];
      got.payload_valid  = m_axis_tuser[1];
      got.frame_last     = m_axis_tlast;
      got.message_id     = m_axis_tdata[15:0];
      got.message_type   = m_axis_tdata[31:16];
      got.payload_length = m_axis_tdata[47:32];
      got.payload_byte   = m_axis_tdata[55:48];
      results_seen++;
      if (got.header_done === 1'b1) headers_seen++;
      if (got.payload_valid === 1'b1) payload_seen++;
      if (got.frame_last === 1'b1) frames_seen++;
      if (parse_expect.size() == 0) begin
        errors++;
        mismatches++;
        if (mismatches <= ShowLimit) begin
          $display("unexpected result: id=%h type=%h len=%h", got.message_id,
                   got.message_type, got.payload_length);
        end
      end else begin
        want = parse_expect.pop_front();
        if (got.header_done !== want.header_done || got.message_id !== want.message_id ||
            got.message_type !== want.message_type ||
            got.payload_length !== want.payload_length ||
            got.payload_valid !== want.payload_valid ||
            got.payload_byte !== want.payload_byte || got.frame_last !== want.frame_last) begin
          errors++;
          mismatches++;
          if (mismatches <= ShowLimit) begin
            $display("result %0d mismatch: exp hd=%b id=%h ty=%h len=%h pv=%b pb=%h last=%b",
                     results_seen, want.header_done, want.message_id, want.message_type,
                     want.payload_length, want.payload_valid, want.payload_byte,
                     want.frame_last);
            $display("                     got hd=%b id=%h ty=%h len=%h pv=%b pb=%h last=%b",
                     got.header_done, got.message_id, got.message_type, got.payload_length,
                     got.payload_valid, got.payload_byte, got.frame_last);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= RunLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    pr_phase = PH_ID;
    pr_low   = 1'b0;
    pr_id    = '0;
    pr_type  = '0;
    pr_len   = '0;
    pr_left  = '0;

    // Zero-length frame with extreme header values, then one- and two-byte payloads.
    queue_frame(16'hFFFF, 16'h0000, 16'h0000, 1'b0);
    queue_frame(16'h0000, 16'hFFFF, 16'h0001, 1'b0);
    rx_stream[rx_stream.size()-1] = 8'hFF;
    queue_frame(16'hA55A, 16'h5AA5, 16'h0002, 1'b0);
    rx_stream[rx_stream.size()-1] = 8'h80;

    while (rx_stream.size() < BulkBytes) begin
      queue_frame(pick_field(), pick_field(), pick_length(), 1'b1);
    end
    phase_a_end = rx_stream.size() / 3;
    phase_b_end = 2 * rx_stream.size() / 3;

    // Largest length last, with no idling; the stream stops a few payload bytes in.
    rx_stream.push_back(8'h12);
    rx_stream.push_back(8'h34);
    rx_stream.push_back(8'h80);
    rx_stream.push_back(8'h01);
    rx_stream.push_back(8'hFF);
    rx_stream.push_back(8'hFF);
    for (int i = 0; i < 20; i++) rx_stream.push_back(8'($urandom));

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    while (rx_stream.size() != 0 || s_axis_tvalid || parse_expect.size() != 0) begin
      @(posedge clk);
    end
    repeat (5) @(posedge clk);
    errors += parse_expect.size();

    $display("covered %0d frames queued, %0d bytes accepted, %0d results checked",
             frames_queued, bytes_accepted, results_seen);
    $display("seen %0d headers, %0d payload bytes, %0d frame ends, %0d mismatches",
             headers_seen, payload_seen, frames_seen, mismatches);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

>>> length_prefixed_frame_parser.f
design/lpfp_pkg.sv
design/lpfp_core.sv
design/length_prefixed_frame_parser.sv
bench/tb_top.sv
